// File: hdl/cks_pkg.sv
// cks_pkg: shared widths, register indexes, reset values and types for the
// kernel-stream convolution block.
// No dependencies; cks_window, cks_mac and conv2d_kernel_stream refer to it by scoped names.
`default_nettype none

package cks_pkg;

    // payload widths
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int RESULT_W   = 40;
    localparam int COORD_W    = 10;
    localparam int CFG_DATA_W = 11;
    localparam int KSIZE_W    = 3;
    localparam int COEF_IDX_W = 6;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KSIZE  = 2'd2;

    // action codes
    localparam logic ACT_COEF  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // limits and defaults
    localparam int HEIGHT_LIMIT   = 1024;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_KERNEL = 7;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd1024;
    localparam logic [KSIZE_W-1:0]    RST_KSIZE  = 3'd3;

    typedef logic signed [DATA_W-1:0] t_sample;

    // window update control from the pipeline to the line buffers
    typedef struct packed {
        logic    shift;
        t_sample px;
    } t_win_ctl;

    // weight load and capture enables for the multiply-add tree
    typedef struct packed {
        logic                  load;
        logic [COEF_IDX_W-1:0] idx;
        t_sample               coef;
        logic                  cap_prod;
        logic                  cap_part;
        logic                  cap_sum;
    } t_mac_ctl;

    // coordinates that travel with a result
    typedef struct packed {
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic               last;
    } t_tag;

    function automatic int max_of(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // width of an effective kernel size
    function automatic int k_width(input int maxk);
        return max_of($clog2(maxk + 1), KSIZE_W);
    endfunction

endpackage

`default_nettype wire

// File: hdl/cks_ram.sv
// cks_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
`default_nettype none

module cks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/cks_window.sv
// cks_window: K-1 line buffers (one cks_ram per row) and the KxK sample window.
// Depends on cks_pkg and cks_ram.
`default_nettype none

module cks_window #(
    parameter int MAX_WIDTH  = cks_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = cks_pkg::DEF_MAX_KERNEL,
    localparam int PAD_ROW   = MAX_WIDTH + MAX_KERNEL - 1,
    localparam int AW        = (PAD_ROW > 1) ? $clog2(PAD_ROW) : 1,
    localparam int KW        = cks_pkg::k_width(MAX_KERNEL),
    localparam int N         = MAX_KERNEL * MAX_KERNEL
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire cks_pkg::t_win_ctl i_ctl,
    input  wire logic [KW-1:0]     i_k,
    output cks_pkg::t_sample       o_window [N]
);

    localparam int LR = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

    logic [cks_pkg::DATA_W-1:0] rdata [LR];
    logic [cks_pkg::DATA_W-1:0] wdata [LR];
    logic                       we    [LR];
    cks_pkg::t_sample           col   [MAX_KERNEL];
    cks_pkg::t_sample           r_win [N];
    cks_pkg::t_sample           n_win [N];

    // line buffer rows
    for (genvar g = 0; g < LR; g++) begin : g_line
        cks_ram #(
            .WIDTH (cks_pkg::DATA_W),
            .DEPTH (PAD_ROW)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (we[g]),
            .i_waddr (i_wr_addr),
            .i_wdata (wdata[g]),
            .i_re    (i_rd_en),
            .i_raddr (i_rd_addr),
            .o_rdata (rdata[g])
        );
    end

    // rows move up by one, the new pixel lands in the youngest row
    always_comb begin
        for (int j = 0; j < LR; j++) begin
            we[j]    = i_ctl.shift && (j + 1 < int'(i_k));
            wdata[j] = (j + 2 == int'(i_k)) ? i_ctl.px : rdata[(j + 1 < LR) ? j + 1 : j];
        end
    end

    // column of samples entering the window
    always_comb begin
        for (int ky = 0; ky < MAX_KERNEL; ky++) begin
            col[ky] = (ky + 1 < int'(i_k)) ? cks_pkg::t_sample'(rdata[(ky < LR) ? ky : 0])
                                            : i_ctl.px;
        end
    end

    // window shifts left by one column
    always_comb begin
        n_win = r_win;
        for (int ky = 0; ky < MAX_KERNEL; ky++) begin
            for (int kx = 0; kx < MAX_KERNEL; kx++) begin
                if (ky < int'(i_k)) begin
                    if (kx + 1 < int'(i_k)) begin
                        n_win[ky*MAX_KERNEL+kx] =
                            r_win[ky*MAX_KERNEL + ((kx + 1 < MAX_KERNEL) ? kx + 1 : kx)];
                    end else if (kx + 1 == int'(i_k)) begin
                        n_win[ky*MAX_KERNEL+kx] = col[ky];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctl.shift) begin
            r_win <= n_win;
        end
    end

    assign o_window = r_win;

endmodule

`default_nettype wire

// File: hdl/cks_mac.sv
// cks_mac: coefficient store, KxK multiplier lanes and a two-level registered adder tree.
// Depends on cks_pkg.
`default_nettype none

module cks_mac #(
    parameter int MAX_KERNEL = cks_pkg::DEF_MAX_KERNEL,
    localparam int KW        = cks_pkg::k_width(MAX_KERNEL),
    localparam int N         = MAX_KERNEL * MAX_KERNEL
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire cks_pkg::t_mac_ctl                   i_ctl,
    input  wire logic [KW-1:0]                       i_k,
    input  wire cks_pkg::t_sample                    i_window [N],
    output logic signed [cks_pkg::RESULT_W-1:0]      o_result
);

    localparam int IW = (N > 1) ? $clog2(N) : 1;

    cks_pkg::t_sample                        r_wt   [N];
    logic [IW-1:0]                           wsel   [N];
    logic                                    use_tap[N];
    logic signed [cks_pkg::PROD_W-1:0]       n_prod [N];
    logic signed [cks_pkg::PROD_W-1:0]       r_prod [N];
    logic signed [cks_pkg::RESULT_W-1:0]     n_part [MAX_KERNEL];
    logic signed [cks_pkg::RESULT_W-1:0]     r_part [MAX_KERNEL];
    logic signed [cks_pkg::RESULT_W-1:0]     n_sum;
    logic signed [cks_pkg::RESULT_W-1:0]     r_sum;

    // coefficient store, out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_wt[i] <= '0;
            end
        end else if (i_ctl.load && (int'(i_ctl.idx) < N)) begin
            r_wt[IW'(i_ctl.idx)] <= i_ctl.coef;
        end
    end

    // weight for each window tap is packed row-major by the active K
    always_comb begin
        for (int ky = 0; ky < MAX_KERNEL; ky++) begin
            for (int kx = 0; kx < MAX_KERNEL; kx++) begin
                use_tap[ky*MAX_KERNEL+kx] = (ky < int'(i_k)) && (kx < int'(i_k));
                wsel[ky*MAX_KERNEL+kx]    = IW'(ky * int'(i_k) + kx);
            end
        end
    end

    // multiplier lanes, signed 16x16
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_prod[i] = '0;
            if (use_tap[i]) begin
                n_prod[i] = r_wt[wsel[i]] * i_window[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_prod) begin
            r_prod <= n_prod;
        end
    end

    // row sums
    always_comb begin
        for (int ky = 0; ky < MAX_KERNEL; ky++) begin
            n_part[ky] = '0;
            for (int kx = 0; kx < MAX_KERNEL; kx++) begin
                n_part[ky] = n_part[ky]
                           + cks_pkg::RESULT_W'(r_prod[ky*MAX_KERNEL+kx]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_part) begin
            r_part <= n_part;
        end
    end

    // final sum
    always_comb begin
        n_sum = '0;
        for (int ky = 0; ky < MAX_KERNEL; ky++) begin
            n_sum = n_sum + r_part[ky];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_result = r_sum;

endmodule

`default_nettype wire

// File: hdl/conv2d_kernel_stream.sv
// conv2d_kernel_stream: top level; configuration registers, raster counters,
// pipeline valids and the output register. Depends on cks_pkg, cks_window, cks_mac.
//
//   channel   direction  handshake                 payload
//   cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//   in        in         i_in_valid/o_in_ready     i_action, i_coef_index, i_coefficient, i_pixel
//   out       out        o_out_valid/i_out_ready   o_result, o_out_x, o_out_y, o_last
//
// One item per clock sustained while i_out_ready is high.
// Five stages: line buffer read, window shift, multiplier lanes, row sums, final sum.
// Each stage moves when the next one is empty or moving, so bubbles close up and a
// new item is taken while a result waits at the output, as long as a stage is empty.
// Reset is synchronous; line buffers need no clearing, rows are filled before use.
`default_nettype none

module conv2d_kernel_stream #(
    parameter int MAX_WIDTH  = cks_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = cks_pkg::DEF_MAX_KERNEL
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [cks_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [cks_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // input items
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_action,
    input  wire logic [cks_pkg::COEF_IDX_W-1:0]         i_coef_index,
    input  wire logic signed [cks_pkg::DATA_W-1:0]      i_coefficient,
    input  wire logic signed [cks_pkg::DATA_W-1:0]      i_pixel,
    // results
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [cks_pkg::RESULT_W-1:0]         o_result,
    output logic [cks_pkg::COORD_W-1:0]                 o_out_x,
    output logic [cks_pkg::COORD_W-1:0]                 o_out_y,
    output logic                                        o_last
);

    localparam int PAD_ROW = MAX_WIDTH + MAX_KERNEL - 1;
    localparam int AW      = (PAD_ROW > 1) ? $clog2(PAD_ROW) : 1;
    localparam int KW      = cks_pkg::k_width(MAX_KERNEL);
    localparam int CW      = cks_pkg::max_of(cks_pkg::CFG_DATA_W,
                                             $clog2(MAX_WIDTH + MAX_KERNEL)) + 1;
    localparam int RW      = cks_pkg::max_of(cks_pkg::CFG_DATA_W,
                                             $clog2(cks_pkg::HEIGHT_LIMIT + MAX_KERNEL)) + 1;
    localparam int N       = MAX_KERNEL * MAX_KERNEL;

    // configuration and counters
    logic [cks_pkg::CFG_DATA_W-1:0] r_width;
    logic [cks_pkg::CFG_DATA_W-1:0] r_height;
    logic [cks_pkg::KSIZE_W-1:0]    r_ksize;
    logic [CW-1:0]                  r_col, n_col;
    logic [RW-1:0]                  r_row, n_row;

    // effective settings
    logic [KW-1:0] k_eff;
    logic [CW-1:0] w_eff, pw, km1_c, c, col_inc, ox;
    logic [RW-1:0] h_eff, rlim, km1_r, r, row_inc, oy;
    logic          emit;
    logic          cfg_hit;

    // pipeline
    logic                   in_xfer, cfg_xfer;
    logic                   rdy1, rdy2, rdy3, rdy4, rdy5, adv1;
    logic                   r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                   r_s1_pix, r_s1_emit;
    logic [AW-1:0]          r_s1_col;
    cks_pkg::t_sample       r_s1_px, r_s1_coef;
    logic [cks_pkg::COEF_IDX_W-1:0] r_s1_idx;
    cks_pkg::t_tag          s0_tag, r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;
    cks_pkg::t_win_ctl      win_ctl;
    cks_pkg::t_mac_ctl      mac_ctl;
    cks_pkg::t_sample       window [N];

    // effective kernel, width and height
    always_comb begin
        k_eff = (KW'(r_ksize) > KW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(r_ksize);
        if (k_eff == '0) begin
            k_eff = KW'(1);
        end
        if (!k_eff[0]) begin
            k_eff = k_eff - KW'(1);
        end
        w_eff = CW'(r_width);
        if (w_eff == '0) begin
            w_eff = CW'(1);
        end
        if (w_eff > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end
        h_eff = RW'(r_height);
        if (h_eff == '0) begin
            h_eff = RW'(1);
        end
        if (h_eff > RW'(cks_pkg::HEIGHT_LIMIT)) begin
            h_eff = RW'(cks_pkg::HEIGHT_LIMIT);
        end
    end

    // padded position, output coordinates and next position
    always_comb begin
        km1_c   = CW'(k_eff) - CW'(1);
        km1_r   = RW'(k_eff) - RW'(1);
        pw      = w_eff + km1_c;
        rlim    = h_eff + km1_r;
        c       = (r_col >= pw) ? '0 : r_col;
        r       = (r_row >= rlim) ? '0 : r_row;
        emit    = (c >= km1_c) && (r >= km1_r);
        ox      = c - km1_c;
        oy      = r - km1_r;
        s0_tag.ox   = ox[cks_pkg::COORD_W-1:0];
        s0_tag.oy   = oy[cks_pkg::COORD_W-1:0];
        s0_tag.last = (ox == w_eff - CW'(1)) && (oy == h_eff - RW'(1));
        col_inc = c + CW'(1);
        row_inc = r + RW'(1);
        if (col_inc >= pw) begin
            n_col = '0;
            n_row = (row_inc >= rlim) ? '0 : row_inc;
        end else begin
            n_col = col_inc;
            n_row = r;
        end
    end

    // stage readiness, bubbles collapse
    assign rdy5       = !r_v5 || i_out_ready;
    assign rdy4       = !r_v4 || rdy5;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign adv1       = r_v1 && rdy2;
    assign o_in_ready = rdy1;
    assign in_xfer    = i_in_valid && rdy1;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer   = i_cfg_valid;

    // register decode
    always_comb begin
        unique case (i_cfg_index)
            cks_pkg::REG_WIDTH, cks_pkg::REG_HEIGHT, cks_pkg::REG_KSIZE: cfg_hit = 1'b1;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cks_pkg::RST_WIDTH;
            r_height <= cks_pkg::RST_HEIGHT;
            r_ksize  <= cks_pkg::RST_KSIZE;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                cks_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                cks_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                cks_pkg::REG_KSIZE:  r_ksize  <= i_cfg_data[cks_pkg::KSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // raster counters, a register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_xfer && cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xfer && (i_action == cks_pkg::ACT_PIXEL)) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1 && r_s1_pix && r_s1_emit;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_pix  <= (i_action == cks_pkg::ACT_PIXEL);
            r_s1_emit <= emit;
            r_s1_col  <= c[AW-1:0];
            r_s1_px   <= i_pixel;
            r_s1_coef <= i_coefficient;
            r_s1_idx  <= i_coef_index;
            r_s1_tag  <= s0_tag;
        end
        if (rdy2) r_s2_tag <= r_s1_tag;
        if (rdy3) r_s3_tag <= r_s2_tag;
        if (rdy4) r_s4_tag <= r_s3_tag;
        if (rdy5) r_s5_tag <= r_s4_tag;
    end

    // window and coefficient controls
    always_comb begin
        win_ctl.shift    = adv1 && r_s1_pix;
        win_ctl.px       = r_s1_px;
        mac_ctl.load     = adv1 && !r_s1_pix;
        mac_ctl.idx      = r_s1_idx;
        mac_ctl.coef     = r_s1_coef;
        mac_ctl.cap_prod = r_v2 && rdy3;
        mac_ctl.cap_part = r_v3 && rdy4;
        mac_ctl.cap_sum  = r_v4 && rdy5;
    end

    cks_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer && (i_action == cks_pkg::ACT_PIXEL)),
        .i_rd_addr (c[AW-1:0]),
        .i_wr_addr (r_s1_col),
        .i_ctl     (win_ctl),
        .i_k       (k_eff),
        .o_window  (window)
    );

    cks_mac #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_k      (k_eff),
        .i_window (window),
        .o_result (o_result)
    );

    assign o_out_valid = r_v5;
    assign o_out_x     = r_s5_tag.ox;
    assign o_out_y     = r_s5_tag.oy;
    assign o_last      = r_s5_tag.last;

endmodule

`default_nettype wire

// File: test/cks_checker.sv
// cks_checker: watches the cfg, in and out channels of conv2d_kernel_stream,
// predicts every result and compares it with what the block delivers.
// Depends on cks_pkg for widths, register indexes and action codes.
module cks_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [cks_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cks_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_action,
    input  logic [cks_pkg::COEF_IDX_W-1:0]        i_coef_index,
    input  logic signed [cks_pkg::DATA_W-1:0]     i_coefficient,
    input  logic signed [cks_pkg::DATA_W-1:0]     i_pixel,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [cks_pkg::RESULT_W-1:0]   i_result,
    input  logic [cks_pkg::COORD_W-1:0]           i_out_x,
    input  logic [cks_pkg::COORD_W-1:0]           i_out_y,
    input  logic                                  i_last,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cks_pkg::*;

    localparam int MAXW  = DEF_MAX_WIDTH;
    localparam int MAXK  = DEF_MAX_KERNEL;
    localparam int PADW  = MAXW + MAXK - 1;

    typedef struct {
        logic signed [RESULT_W-1:0] sum;
        logic [COORD_W-1:0]         ox;
        logic [COORD_W-1:0]         oy;
        logic                       last;
    } t_conv_out;

    t_conv_out   conv_q[$];
    t_sample     line_rows[0:MAXK-2][0:PADW-1];
    t_sample     win[0:MAXK-1][0:MAXK-1];
    t_sample     taps[0:MAXK*MAXK-1];
    int unsigned col_pos, row_pos;
    logic [CFG_DATA_W-1:0] cfg_w, cfg_h;
    logic [KSIZE_W-1:0]    cfg_k;
    int          fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = conv_q.size();

    // effective register values after clamping
    function automatic int unsigned k_eff();
        int unsigned k;
        k = cfg_k;
        if (k > MAXK) k = MAXK;
        if (k == 0) k = 1;
        if (k % 2 == 0) k = k - 1;
        return k;
    endfunction

    function automatic int unsigned w_eff();
        int unsigned w;
        w = cfg_w;
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int unsigned h_eff();
        int unsigned h;
        h = cfg_h;
        if (h == 0) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return h;
    endfunction

    // one pixel through line rows and window; queues a result when the window is valid
    task automatic push_pixel(input t_sample px);
        int unsigned k, w, h, pw, c, r;
        t_sample     colv[0:MAXK-1];
        longint      acc;
        t_conv_out   o;
        k  = k_eff();
        w  = w_eff();
        h  = h_eff();
        pw = w + k - 1;
        c  = col_pos;
        r  = row_pos;
        if (c >= pw) c = 0;
        if (r >= h + k - 1) r = 0;
        for (int ky = 0; ky + 1 < k; ky++) colv[ky] = line_rows[ky][c];
        colv[k-1] = px;
        for (int ky = 0; ky + 2 < k; ky++) line_rows[ky][c] = line_rows[ky+1][c];
        if (k > 1) line_rows[k-2][c] = px;
        for (int ky = 0; ky < k; ky++) begin
            for (int kx = 0; kx + 1 < k; kx++) win[ky][kx] = win[ky][kx+1];
            win[ky][k-1] = colv[ky];
        end
        if (c >= k - 1 && r >= k - 1) begin
            acc = 0;
            for (int ky = 0; ky < k; ky++)
                for (int kx = 0; kx < k; kx++)
                    acc += longint'(taps[ky*k+kx]) * longint'(win[ky][kx]);
            o.sum  = acc[RESULT_W-1:0];
            o.ox   = COORD_W'(c - (k - 1));
            o.oy   = COORD_W'(r - (k - 1));
            o.last = (c - (k - 1) == w - 1) && (r - (k - 1) == h - 1);
            conv_q.push_back(o);
        end
        c++;
        if (c >= pw) begin
            c = 0;
            r++;
            if (r >= h + k - 1) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge i_clk) begin
        t_conv_out e;
        if (!i_rst_n) begin
            for (int i = 0; i < MAXK - 1; i++)
                for (int j = 0; j < PADW; j++) line_rows[i][j] = '0;
            for (int i = 0; i < MAXK; i++)
                for (int j = 0; j < MAXK; j++) win[i][j] = '0;
            for (int i = 0; i < MAXK * MAXK; i++) taps[i] = '0;
            col_pos = 0;
            row_pos = 0;
            cfg_w   = RST_WIDTH;
            cfg_h   = RST_HEIGHT;
            cfg_k   = RST_KSIZE;
            conv_q.delete();
        end else begin
            // register write restarts the frame
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT
                        || i_cfg_index == REG_KSIZE) begin
                    if (i_cfg_index == REG_WIDTH) cfg_w = i_cfg_data;
                    else if (i_cfg_index == REG_HEIGHT) cfg_h = i_cfg_data;
                    else cfg_k = i_cfg_data[KSIZE_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            // input transfer
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_COEF) begin
                    if (i_coef_index < MAXK * MAXK) taps[i_coef_index] = i_coefficient;
                end else begin
                    push_pixel(i_pixel);
                end
            end
            // result transfer
            if (i_out_valid && i_out_ready) begin
                if (conv_q.size() == 0) begin
                    $error("unexpected result transfer: result %0d x %0d y %0d",
                           i_result, i_out_x, i_out_y);
                    fails++;
                end else begin
                    e = conv_q.pop_front();
                    if (i_result !== e.sum) begin
                        $error("result mismatch: expected %0d actual %0d", e.sum, i_result);
                        fails++;
                    end
                    if (i_out_x !== e.ox) begin
                        $error("out_x mismatch: expected %0d actual %0d", e.ox, i_out_x);
                        fails++;
                    end
                    if (i_out_y !== e.oy) begin
                        $error("out_y mismatch: expected %0d actual %0d", e.oy, i_out_y);
                        fails++;
                    end
                    if (i_last !== e.last) begin
                        $error("last mismatch: expected %0d actual %0d", e.last, i_last);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

// File: test/testbench.sv
// testbench: clock, reset and stimulus for conv2d_kernel_stream; results are
// checked by cks_checker. Depends on cks_pkg, cks_checker and the RTL in hdl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cks_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int ITEM_GOAL   = 1850;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic                         i_action;
    logic [COEF_IDX_W-1:0]        i_coef_index;
    logic signed [DATA_W-1:0]     i_coefficient;
    logic signed [DATA_W-1:0]     i_pixel;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic signed [RESULT_W-1:0]   o_result;
    logic [COORD_W-1:0]           o_out_x;
    logic [COORD_W-1:0]           o_out_y;
    logic                         o_last;
    int                           fail_count;
    int                           pending;
    int                           item_count;
    int                           burst_left;
    bit                           use_gaps;
    int                           quiet_cycles = 0;

    conv2d_kernel_stream u_top (.*);

    cks_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_coef_index  (i_coef_index),
        .i_coefficient (i_coefficient),
        .i_pixel       (i_pixel),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_result      (o_result),
        .i_out_x       (o_out_x),
        .i_out_y       (o_out_y),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern: i_out_ready follows a randomly chosen mode
    int stall_mode = 0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
        stall_tick++;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ((stall_tick / 8) % 2 == 0);
        endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
                || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // wait until no result is outstanding and the pipeline has drained
    task automatic settle();
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one input transfer, then, with gaps enabled, a random gap at the end of a burst
    task automatic send_item(input logic act, input logic [COEF_IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] coef,
                             input logic signed [DATA_W-1:0] px);
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_coef_index  <= idx;
        i_coefficient <= coef;
        i_pixel       <= px;
        do @(posedge i_clk); while (!o_in_ready);
        item_count++;
        if (use_gaps) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic stop_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // pixels with occasional coefficient loads mixed in
    task automatic stream_pixels(input int n, input int coef_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < coef_pct)
                send_item(ACT_COEF, COEF_IDX_W'($urandom), rand_sample(),
                          DATA_W'($urandom));
            send_item(ACT_PIXEL, COEF_IDX_W'($urandom), DATA_W'($urandom), rand_sample());
        end
        stop_input();
    endtask

    task automatic set_frame(input int w, input int h, input int k);
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_KSIZE, CFG_DATA_W'(k));
    endtask

    initial begin
        int w, h, k, ke, n;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_WIDTH;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_COEF;
        i_coef_index  <= '0;
        i_coefficient <= '0;
        i_pixel       <= '0;
        item_count    = 0;
        burst_left    = 0;
        use_gaps      = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a few pixels under reset defaults, then coefficient extremes
        send_item(ACT_PIXEL, '0, '0, 16'sh7fff);
        send_item(ACT_PIXEL, '0, '0, 16'sh8000);
        send_item(ACT_COEF, 6'd0, 16'sh8000, '0);
        send_item(ACT_COEF, 6'd4, 16'sh7fff, '0);
        send_item(ACT_COEF, 6'd8, 16'sh8000, '0);
        send_item(ACT_COEF, 6'd48, 16'sh7fff, '0);   // stored, outside 3x3
        send_item(ACT_COEF, 6'd63, 16'sh1234, '0);   // beyond the store, ignored
        send_item(ACT_COEF, 6'd49, 16'sh7fff, '0);   // beyond the store, ignored
        stop_input();
        // 2x2 output with K=3: 4x4 padded pixels at the extremes
        set_frame(2, 2, 3);
        write_reg(REG_SPARE, 11'h7ff);               // unused index, no effect
        for (int i = 0; i < 16; i++)
            send_item(ACT_PIXEL, '0, '0, (i % 3 == 0) ? 16'sh8000 : 16'sh7fff);
        stop_input();

        // widest row: width above the limit acts as the limit
        use_gaps = 1'b1;
        set_frame(11'h7ff, 1, 1);
        stream_pixels(1024, 2);
        // start of the tallest column with an all-ones height
        use_gaps = 1'b0;
        set_frame(1, 11'h7ff, 0);
        stream_pixels(300, 2);

        // random frames, with every clamp case of the registers
        while (item_count < ITEM_GOAL) begin
            use_gaps = $urandom_range(0, 3) != 0;
            w = $urandom_range(0, 10);
            h = $urandom_range(0, 6);
            k = $urandom_range(0, 7);
            if ($urandom_range(0, 9) == 0) begin
                // all-ones on one register, frame cut short
                if ($urandom_range(0, 1)) w = 11'h7ff;
                else h = 11'h7ff;
            end
            set_frame(w, h, k);
            // a full load of kernel weights first
            for (int i = 0; i < 49; i++)
                send_item(ACT_COEF, COEF_IDX_W'(i), rand_sample(), DATA_W'($urandom));
            ke = (k > 7) ? 7 : ((k == 0) ? 1 : ((k % 2 == 0) ? k - 1 : k));
            n = (((w == 0) ? 1 : (w > 1024 ? 1024 : w)) + ke - 1)
                * (((h == 0) ? 1 : (h > 1024 ? 1024 : h)) + ke - 1);
            if (n > 300) n = 300;
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
            stream_pixels(n, 5);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
